/* design/spef_pkg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// spef_pkg
// Shared types and constants for the SPI EEPROM page write framer.
// -----------------------------------------------------------------------------
package spef_pkg;

   localparam int DefPageBytes = 32;
   localparam int DefMemBytes  = 8192;

   localparam int OffsetWidth = 13;
   localparam int CountWidth  = 14;
   localparam int ByteWidth   = 8;
   localparam int BaseWidth   = 13;

   localparam int MaxResults  = 5;
   localparam int NumWidth    = 3;

   localparam logic [7:0] CMD_READ  = 8'h03;
   localparam logic [7:0] CMD_WRITE = 8'h02;
   localparam logic [7:0] CMD_WREN  = 8'h06;

   localparam logic CSR_REGION_BASE = 1'b0;
   localparam logic CSR_REGION_SIZE = 1'b1;

   typedef enum logic [1:0] {
      FUNC_READ  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_DATA  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      STATUS_SPI        = 2'd0,
      STATUS_ACCEPT     = 2'd1,
      STATUS_RANGE      = 2'd2,
      STATUS_UNEXPECTED = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]             func;
      logic [OffsetWidth-1:0] offset;
      logic [CountWidth-1:0]  byte_count;
      logic [ByteWidth-1:0]   prog_byte;
   } item_type;

   typedef struct packed {
      status_type           status;
      logic [ByteWidth-1:0] spi_byte;
      logic                 select_begin;
      logic                 select_end;
      logic                 wait_ready;
      logic                 last;
   } result_type;

   typedef struct packed {
      logic [NumWidth-1:0] count;
      logic                can_load;
   } queue_status_type;

endpackage : spef_pkg
`default_nettype wire

/* design/spef_framer.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// spef_framer
// Builds the full result list for one item and holds the write progress state.
// -----------------------------------------------------------------------------
module spef_framer #(
   parameter int PAGE_BYTES = spef_pkg::DefPageBytes,
   parameter int MEM_BYTES  = spef_pkg::DefMemBytes
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 fire,
   input  spef_pkg::item_type                  item,
   input  wire  [spef_pkg::BaseWidth-1:0]      region_base,
   input  wire  [spef_pkg::CountWidth-1:0]     region_size,
   output spef_pkg::result_type                results [spef_pkg::MaxResults],
   output logic [spef_pkg::NumWidth-1:0]       num_results
);
   import spef_pkg::*;

   localparam int AddrWidth  = $clog2(MEM_BYTES);
   localparam int PageWidth  = $clog2(PAGE_BYTES);
   localparam int ChunkWidth = PageWidth + 1;

   logic [AddrWidth-1:0]  write_address_ff,   write_address_in;
   logic [CountWidth-1:0] bytes_remaining_ff, bytes_remaining_in;
   logic [ChunkWidth-1:0] chunk_remaining_ff, chunk_remaining_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         write_address_ff   <= '0;
         bytes_remaining_ff <= '0;
         chunk_remaining_ff <= '0;
      end else if (fire) begin
         write_address_ff   <= write_address_in;
         bytes_remaining_ff <= bytes_remaining_in;
         chunk_remaining_ff <= chunk_remaining_in;
      end
   end

   always_comb begin
      logic [16:0]           addr_sum;
      logic [AddrWidth-1:0]  addr;
      logic [15:0]           addr16;
      logic [15:0]           wa16;
      logic [14:0]           span;
      logic                  fits;
      logic [ChunkWidth-1:0] room;
      logic [ChunkWidth-1:0] chunk;
      logic [CountWidth-1:0] bytes_left;
      logic [NumWidth-1:0]   n;

      addr_sum = 17'(region_base) + 17'(item.offset);
      addr     = addr_sum[AddrWidth-1:0];
      addr16   = 16'(addr);
      wa16     = 16'(write_address_ff);
      span     = 15'(item.offset) + 15'(item.byte_count);
      fits     = span <= 15'(region_size);
      room     = ChunkWidth'(PAGE_BYTES) - ChunkWidth'(write_address_ff[PageWidth-1:0]);
      chunk    = chunk_remaining_ff;
      bytes_left = bytes_remaining_ff - CountWidth'(1);
      n        = '0;

      write_address_in   = write_address_ff;
      bytes_remaining_in = bytes_remaining_ff;
      chunk_remaining_in = chunk_remaining_ff;

      for (int i = 0; i < MaxResults; i++) begin
         results[i] = '0;
      end

      case (func_type'(item.func))
         FUNC_READ, FUNC_WRITE: begin
            if (bytes_remaining_ff != '0) begin
               results[0] = '{STATUS_UNEXPECTED, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1};
               n = NumWidth'(1);
            end else if (!fits) begin
               results[0] = '{STATUS_RANGE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1};
               n = NumWidth'(1);
            end else if (func_type'(item.func) == FUNC_READ) begin
               results[0] = '{STATUS_SPI, CMD_READ, 1'b1, 1'b0, 1'b1, 1'b0};
               results[1] = '{STATUS_SPI, addr16[15:8], 1'b0, 1'b0, 1'b0, 1'b0};
               results[2] = '{STATUS_SPI, addr16[7:0], 1'b0,
                              item.byte_count == '0, 1'b0, 1'b1};
               n = NumWidth'(3);
            end else begin
               write_address_in   = addr;
               bytes_remaining_in = item.byte_count;
               chunk_remaining_in = '0;
               results[0] = '{STATUS_ACCEPT, 8'h00, 1'b0, 1'b0,
                              item.byte_count == '0, 1'b1};
               n = NumWidth'(1);
            end
         end
         FUNC_DATA: begin
            if (bytes_remaining_ff == '0) begin
               results[0] = '{STATUS_UNEXPECTED, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1};
               n = NumWidth'(1);
            end else begin
               // A new chunk opens with a WREN frame and the WRITE header.
               if (chunk_remaining_ff == '0) begin
                  chunk = (bytes_remaining_ff < CountWidth'(room))
                        ? bytes_remaining_ff[ChunkWidth-1:0] : room;
                  results[0] = '{STATUS_SPI, CMD_WREN,  1'b1, 1'b1, 1'b1, 1'b0};
                  results[1] = '{STATUS_SPI, CMD_WRITE, 1'b1, 1'b0, 1'b0, 1'b0};
                  results[2] = '{STATUS_SPI, wa16[15:8], 1'b0, 1'b0, 1'b0, 1'b0};
                  results[3] = '{STATUS_SPI, wa16[7:0],  1'b0, 1'b0, 1'b0, 1'b0};
                  n = NumWidth'(4);
               end
               chunk_remaining_in = chunk - ChunkWidth'(1);
               bytes_remaining_in = bytes_left;
               write_address_in   = write_address_ff + AddrWidth'(1);
               results[n] = '{STATUS_SPI, item.prog_byte, 1'b0,
                              chunk_remaining_in == '0, bytes_left == '0, 1'b1};
               n = n + NumWidth'(1);
            end
         end
         default: begin
            results[0] = '{STATUS_UNEXPECTED, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1};
            n = NumWidth'(1);
         end
      endcase

      num_results = n;
   end

endmodule : spef_framer
`default_nettype wire

/* design/spef_rsp_queue.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// spef_rsp_queue
// Result buffer: loads a whole result list at once and shifts it out.
// -----------------------------------------------------------------------------
module spef_rsp_queue (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             load,
   input  spef_pkg::result_type            load_results [spef_pkg::MaxResults],
   input  wire  [spef_pkg::NumWidth-1:0]   load_count,
   input  wire                             rsp_tready,
   output logic                            rsp_tvalid,
   output spef_pkg::result_type            rsp_result,
   output spef_pkg::queue_status_type      queue_status
);
   import spef_pkg::*;

   result_type          entry_ff [MaxResults];
   logic [NumWidth-1:0] count_ff, count_in;
   logic                transfer;

   assign transfer = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = count_ff != '0;
   assign rsp_result = entry_ff[0];

   // The list may be replaced in the cycle its final entry leaves.
   assign queue_status.can_load = (count_ff == '0) ||
                                  (count_ff == NumWidth'(1) && rsp_tready);
   assign queue_status.count = count_ff;

   always_comb begin
      count_in = count_ff;
      if (load) begin
         count_in = load_count;
      end else if (transfer) begin
         count_in = count_ff - NumWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < MaxResults; i++) begin
            entry_ff[i] <= load_results[i];
         end
      end else if (transfer) begin
         for (int i = 0; i < MaxResults - 1; i++) begin
            entry_ff[i] <= entry_ff[i+1];
         end
         entry_ff[MaxResults-1] <= '0;
      end
   end

endmodule : spef_rsp_queue
`default_nettype wire

/* design/spi_eeprom_page_write_framer.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// spi_eeprom_page_write_framer
// Turns EEPROM read/write requests and data bytes into framed SPI bytes.
// -----------------------------------------------------------------------------
// Usage:
// Requests and data bytes arrive on the req_ stream; func travels in req_tuser.
// Each accepted transfer yields one to five result transfers on the rsp_
// stream, with the result status in rsp_tuser and rsp_tlast on the final one.
// A read yields READ plus two address bytes; a write request yields a single
// accept; each data byte yields one transfer, or five at the start of a page
// chunk (WREN, WRITE, two address bytes, data).
// An item waits in the input register until the buffer can take its list,
// is framed in one pass into the result buffer, and its first result
// appears the next cycle. Lists leave one at a time: the result port moves
// one transfer per cycle while rsp_tready is high, and the next item is
// framed in the cycle the previous list's final transfer leaves.
// When the receiver stalls, the buffer holds its list, one item waits in the
// input register and req_tready drops. Reset clears the write progress, the
// buffer and the input register, and sets the region to base 0, size DefMemBytes.
// The csr_ port must be written only while the block is idle; the block does
// not enforce this. PAGE_BYTES and MEM_BYTES must be powers of two.
// -----------------------------------------------------------------------------
module spi_eeprom_page_write_framer #(
   parameter int PAGE_BYTES = spef_pkg::DefPageBytes,
   parameter int MEM_BYTES  = spef_pkg::DefMemBytes
) (
   input  wire         clock,
   input  wire         reset,
   // Configuration write port.
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire  [13:0] csr_wdata,
   // Input stream.
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,  // offset[12:0], byte_count[26:13], prog_byte[34:27]
   input  wire  [1:0]  req_tuser,  // func[1:0]
   // Result stream.
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,  // spi_byte[7:0], select_begin[8], select_end[9],
                                   // wait_ready[10]
   output logic [1:0]  rsp_tuser,  // status[1:0]
   output logic        rsp_tlast
);
   import spef_pkg::*;

   // Configuration registers.
   logic [BaseWidth-1:0]  region_base_ff;
   logic [CountWidth-1:0] region_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff <= '0;
         region_size_ff <= CountWidth'(DefMemBytes);
      end else if (csr_we) begin
         case (csr_index)
            CSR_REGION_BASE: region_base_ff <= csr_wdata[BaseWidth-1:0];
            CSR_REGION_SIZE: region_size_ff <= csr_wdata[CountWidth-1:0];
            default: ;
         endcase
      end
   end

   // Input register. An item waits here until the result buffer can take its
   // complete list; it is then framed and written to the buffer in one step.
   item_type         item_ff;
   logic             item_valid_ff, item_valid_in;
   logic             load;
   queue_status_type queue_status;
   result_type       frame_results [MaxResults];
   logic [NumWidth-1:0] frame_count;
   result_type       rsp_result;

   assign load       = item_valid_ff && queue_status.can_load;
   assign req_tready = !item_valid_ff || load;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_tvalid && req_tready) begin
         item_valid_in = 1'b1;
      end else if (load) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.func       <= req_tuser;
         item_ff.offset     <= req_tdata[12:0];
         item_ff.byte_count <= req_tdata[26:13];
         item_ff.prog_byte  <= req_tdata[34:27];
      end
   end

   // Framing logic and write progress state.
   spef_framer #(
      .PAGE_BYTES (PAGE_BYTES),
      .MEM_BYTES  (MEM_BYTES)
   ) u_framer (
      .clock       (clock),
      .reset       (reset),
      .fire        (load),
      .item        (item_ff),
      .region_base (region_base_ff),
      .region_size (region_size_ff),
      .results     (frame_results),
      .num_results (frame_count)
   );

   // Result buffer feeding the output stream.
   spef_rsp_queue u_rsp_queue (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .load_results (frame_results),
      .load_count   (frame_count),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_result   (rsp_result),
      .queue_status (queue_status)
   );

   assign rsp_tdata = {5'b00000, rsp_result.wait_ready, rsp_result.select_end,
                       rsp_result.select_begin, rsp_result.spi_byte};
   assign rsp_tuser = rsp_result.status;
   assign rsp_tlast = rsp_result.last;

   // An item waiting for the buffer is kept until it is framed.
   assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !load |=> item_valid_ff)
      else $error("input item dropped before framing");

   // Once the final transfer of a list leaves and nothing new is framed,
   // the buffer is empty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast && !load |=> queue_status.count == '0)
      else $error("result buffer not empty after last transfer");

   // Framing always produces at least one and at most five results.
   assert property (@(posedge clock) disable iff (reset)
      load |-> frame_count != '0 && frame_count <= NumWidth'(MaxResults))
      else $error("bad result count from framer");

   // A freshly framed list is presented on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_tvalid)
      else $error("framed list not presented");

endmodule : spi_eeprom_page_write_framer
`default_nettype wire

/* sim/spi_eeprom_page_write_framer_tb.sv */
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// spi_eeprom_page_write_framer_tb
// Self-checking bench for the SPI EEPROM page write framer.
// -----------------------------------------------------------------------------
// A short table of hand-picked requests and data bytes runs first. Then
// several phases of random traffic follow, each under its own region setting.
// Every accepted request is framed by a behavioral copy of the block. The
// framed bytes are queued, and each result transfer is compared field by field
// with the oldest queued frame. Both stream sides idle and stall at random.
// -----------------------------------------------------------------------------
module spi_eeprom_page_write_framer_tb;
   import spef_pkg::*;

   localparam int ClockPeriod   = 12;
   localparam int ResetCycles   = 5;
   localparam int PageBytes     = DefPageBytes;
   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 16;
   localparam int PhaseItems    = 30;
   localparam int RandomPhases  = 4;

   // The func field is two bits wide, but the package names only three codes.
   // The fourth code must still be answered as an unexpected item.
   localparam logic [1:0] FuncUndefined = 2'd3;

   // Kinds of rows in the directed table.
   typedef enum logic [1:0] {
      ROW_PREDICT,   // The result list comes from the framing model.
      ROW_TYPED,     // One result, typed into the table by hand.
      ROW_CSR        // A register write between items.
   } row_kind_type;

   typedef struct {
      row_kind_type kind;
      item_type     it;
      status_type   st;    // Typed rows: expected status.
      logic         wr;    // Typed rows: expected wait_ready.
      logic         sel;   // Register rows: register index.
   } directed_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic        csr_index  = 1'b0;
   logic [13:0] csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // offset[12:0], byte_count[26:13], prog_byte[34:27]
   logic [1:0]  req_tuser  = '0;   // func[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // spi_byte[7:0], select_begin[8], select_end[9],
                                   // wait_ready[10]
   logic [1:0]  rsp_tuser;         // status[1:0]
   logic        rsp_tlast;

   always #(ClockPeriod / 2) clock = ~clock;

   spi_eeprom_page_write_framer u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // ---------------------------------------------------------------------------
   // Framing model. It keeps its own copy of the region registers and of the
   // progress of the open page write.
   // ---------------------------------------------------------------------------
   logic [BaseWidth-1:0]   region_base_q  = '0;
   logic [CountWidth-1:0]  region_size_q  = 14'd8192;
   logic [OffsetWidth-1:0] next_address   = '0;
   logic [CountWidth-1:0]  bytes_left     = '0;
   logic [7:0]             chunk_left     = '0;

   result_type framed[$];            // Results of the item being framed.
   result_type expected_frames[$];   // Results still owed by the block.

   int  n_fail        = 0;
   bit  sender_steady = 1'b0;
   bit  reader_steady = 1'b0;

   function automatic result_type frame(status_type st, logic [7:0] b, logic sb,
                                        logic se, logic wr, logic lst);
      result_type r;
      r.status       = st;
      r.spi_byte     = b;
      r.select_begin = sb;
      r.select_end   = se;
      r.wait_ready   = wr;
      r.last         = lst;
      return r;
   endfunction

   // Frames one accepted item into the framed queue and updates the write
   // progress. The 13-bit address sum wraps at the device size by itself.
   task automatic frame_item(input item_type it);
      logic [OffsetWidth-1:0] addr;
      int room;
      framed.delete();
      if (it.func == FUNC_READ || it.func == FUNC_WRITE) begin
         if (bytes_left != 0) begin
            // A new request while a write is still open is refused.
            framed.push_back(frame(STATUS_UNEXPECTED, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1));
         end else if (int'(it.offset) + int'(it.byte_count) > int'(region_size_q)) begin
            framed.push_back(frame(STATUS_RANGE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1));
         end else begin
            addr = region_base_q + it.offset;
            if (it.func == FUNC_READ) begin
               // A zero-length read still sends the command. Chip select then
               // drops right after the address low byte.
               framed.push_back(frame(STATUS_SPI, CMD_READ, 1'b1, 1'b0, 1'b1, 1'b0));
               framed.push_back(frame(STATUS_SPI, 8'(addr >> 8), 1'b0, 1'b0, 1'b0, 1'b0));
               framed.push_back(frame(STATUS_SPI, addr[7:0], 1'b0, it.byte_count == 0,
                                      1'b0, 1'b1));
            end else begin
               next_address = addr;
               bytes_left   = it.byte_count;
               chunk_left   = '0;
               framed.push_back(frame(STATUS_ACCEPT, 8'h00, 1'b0, 1'b0,
                                      it.byte_count == 0, 1'b1));
            end
         end
      end else if (it.func == FUNC_DATA && bytes_left != 0) begin
         if (chunk_left == 0) begin
            // A chunk runs up to the next page boundary or to the end of the data.
            room       = PageBytes - (int'(next_address) % PageBytes);
            chunk_left = 8'((int'(bytes_left) < room) ? int'(bytes_left) : room);
            framed.push_back(frame(STATUS_SPI, CMD_WREN, 1'b1, 1'b1, 1'b1, 1'b0));
            framed.push_back(frame(STATUS_SPI, CMD_WRITE, 1'b1, 1'b0, 1'b0, 1'b0));
            framed.push_back(frame(STATUS_SPI, 8'(next_address >> 8), 1'b0, 1'b0, 1'b0,
                                   1'b0));
            framed.push_back(frame(STATUS_SPI, next_address[7:0], 1'b0, 1'b0, 1'b0, 1'b0));
         end
         chunk_left   = chunk_left - 8'd1;
         bytes_left   = bytes_left - 14'd1;
         next_address = next_address + 13'd1;
         framed.push_back(frame(STATUS_SPI, it.prog_byte, 1'b0, chunk_left == 0,
                                bytes_left == 0, 1'b1));
      end else begin
         // Stray data bytes and the undefined func code.
         framed.push_back(frame(STATUS_UNEXPECTED, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1));
      end
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------------

   // Most gaps are short, a few are long.
   function automatic int pause_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Presents one item at the falling edge, holds it until the rising edge at
   // which it transfers, frames it, and returns at the next falling edge. The
   // caller then either presents the next item or lowers req_tvalid.
   task automatic send_item(input item_type it, input bit typed, input result_type hand);
      int gap;
      if ($urandom_range(0, 24) == 0) sender_steady = !sender_steady;
      gap = sender_steady ? 0 : pause_length();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  = it.func;
      req_tdata  = {5'b0, it.prog_byte, it.byte_count, it.offset};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // The model always runs, so its progress stays right on typed rows too.
      frame_item(it);
      if (typed) begin
         expected_frames.push_back(hand);
      end else begin
         foreach (framed[i]) expected_frames.push_back(framed[i]);
      end
      @(negedge clock);
   endtask

   // Register writes wait until every owed result has left the block. Each item
   // yields at least one result, so an empty queue means the block is idle.
   task automatic write_csr(input logic sel, input logic [13:0] value);
      req_tvalid = 1'b0;
      while (expected_frames.size() != 0) @(negedge clock);
      csr_index = sel;
      csr_wdata = value;
      csr_we    = 1'b1;
      @(negedge clock);
      csr_we = 1'b0;
      if (sel == CSR_REGION_BASE) begin
         region_base_q = value[12:0];
      end else begin
         region_size_q = value;
      end
   endtask

   // Random traffic is mostly well-formed: a write request that fits is
   // followed by its data bytes. Noise is sprinkled in: stray data bytes,
   // requests inside a write, the undefined code and random range checks.
   function automatic item_type random_item();
      item_type it;
      int pick, top, cnt;
      it.offset     = 13'($urandom);
      it.byte_count = 14'($urandom);
      it.prog_byte  = 8'($urandom);
      pick          = $urandom_range(0, 99);
      if (bytes_left != 0) begin
         if (pick < 90) it.func = FUNC_DATA;
         else if (pick < 94) it.func = FuncUndefined;
         else it.func = (pick < 97) ? FUNC_READ : FUNC_WRITE;
         return it;
      end
      if (pick >= 85) begin
         it.func = (pick < 92) ? FUNC_DATA : FuncUndefined;
         return it;
      end
      it.func = (pick < 50) ? FUNC_WRITE : FUNC_READ;
      if ($urandom_range(0, 3) != 0) begin
         // Fitting request, mostly short, now and then a few pages long.
         top = ($urandom_range(0, 4) == 0) ? 100 : 40;
         if (top > int'(region_size_q)) top = int'(region_size_q);
         cnt = $urandom_range(0, top);
         top = int'(region_size_q) - cnt;
         if (top > 8191) top = 8191;
         it.byte_count = 14'(cnt);
         it.offset     = 13'($urandom_range(0, top));
      end else if (it.func == FUNC_WRITE) begin
         // A random write always overruns the region, so it never arms a
         // write of thousands of bytes.
         it.byte_count = 14'(int'(region_size_q) + 1 + $urandom_range(0, 99));
      end
      return it;
   endfunction

   function automatic directed_row_type item_row(row_kind_type kind, logic [1:0] func,
                                                 int offset, int count, int data,
                                                 status_type st, logic wr);
      directed_row_type r;
      r.kind             = kind;
      r.it.func          = func;
      r.it.offset        = 13'(offset);
      r.it.byte_count    = 14'(count);
      r.it.prog_byte     = 8'(data);
      r.st               = st;
      r.wr               = wr;
      r.sel              = 1'b0;
      return r;
   endfunction

   function automatic directed_row_type csr_row(logic sel, int value);
      directed_row_type r;
      r     = item_row(ROW_CSR, FUNC_READ, 0, value, 0, STATUS_SPI, 1'b0);
      r.sel = sel;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Result side: random back-pressure and the field-by-field compare.
   // ---------------------------------------------------------------------------
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 31) == 0) reader_steady = !reader_steady;
         if (hold > 0) begin
            hold--;
         end else if (rsp_tready && !reader_steady && $urandom_range(0, 3) == 0) begin
            rsp_tready = 1'b0;
            hold       = pause_length();
         end else begin
            rsp_tready = 1'b1;
            hold       = $urandom_range(0, 24);
         end
      end
   end

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         n_fail++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_frames.size() == 0) begin
            $error("result transfer with no result owed: status %0d, byte %0d",
                   rsp_tuser, rsp_tdata[7:0]);
            n_fail++;
         end else begin
            want = expected_frames.pop_front();
            compare_field("status", want.status, rsp_tuser);
            compare_field("spi_byte", want.spi_byte, rsp_tdata[7:0]);
            compare_field("select_begin", want.select_begin, rsp_tdata[8]);
            compare_field("select_end", want.select_end, rsp_tdata[9]);
            compare_field("wait_ready", want.wait_ready, rsp_tdata[10]);
            compare_field("last", want.last, rsp_tlast);
         end
      end
   end

   // The watchdog counts cycles in which neither side moves a transfer.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WatchdogLimit) begin
         $display("spi_eeprom_page_write_framer test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------------
   initial begin
      directed_row_type directed[$];
      int sent;
      logic [13:0] base_pick, size_pick;

      // Right after reset: a zero-length read, then stray and undefined items.
      directed.push_back(item_row(ROW_PREDICT, FUNC_READ, 0, 0, 8'h00, STATUS_SPI, 1'b0));
      directed.push_back(item_row(ROW_TYPED, FUNC_DATA, 0, 0, 8'hFF,
                                  STATUS_UNEXPECTED, 1'b0));
      directed.push_back(item_row(ROW_TYPED, FuncUndefined, 8191, 16383, 8'hFF,
                                  STATUS_UNEXPECTED, 1'b0));
      // Range checks at both ends of the full device.
      directed.push_back(item_row(ROW_TYPED, FUNC_READ, 8191, 2, 8'h00, STATUS_RANGE, 1'b0));
      directed.push_back(item_row(ROW_PREDICT, FUNC_READ, 0, 8192, 8'h00, STATUS_SPI, 1'b0));
      // A zero-length write is accepted with wait_ready and arms nothing.
      directed.push_back(item_row(ROW_TYPED, FUNC_WRITE, 0, 0, 8'h00, STATUS_ACCEPT, 1'b1));
      directed.push_back(item_row(ROW_TYPED, FUNC_WRITE, 8191, 16383, 8'h00,
                                  STATUS_RANGE, 1'b0));
      // Four bytes from offset 30 cross a page boundary after two bytes.
      directed.push_back(item_row(ROW_TYPED, FUNC_WRITE, 30, 4, 8'h00, STATUS_ACCEPT, 1'b0));
      directed.push_back(item_row(ROW_TYPED, FUNC_READ, 0, 1, 8'h00,
                                  STATUS_UNEXPECTED, 1'b0));
      directed.push_back(item_row(ROW_PREDICT, FUNC_DATA, 0, 0, 8'h00, STATUS_SPI, 1'b0));
      directed.push_back(item_row(ROW_PREDICT, FUNC_DATA, 0, 0, 8'hFF, STATUS_SPI, 1'b0));
      directed.push_back(item_row(ROW_PREDICT, FUNC_DATA, 8191, 16383, 8'hA5,
                                  STATUS_SPI, 1'b0));
      directed.push_back(item_row(ROW_TYPED, FUNC_WRITE, 0, 1, 8'h00,
                                  STATUS_UNEXPECTED, 1'b0));
      directed.push_back(item_row(ROW_PREDICT, FUNC_DATA, 0, 0, 8'h5A, STATUS_SPI, 1'b0));
      // Region at the top of the device: addresses wrap to zero mid-write.
      directed.push_back(csr_row(CSR_REGION_BASE, 8191));
      directed.push_back(item_row(ROW_TYPED, FUNC_WRITE, 0, 3, 8'h00, STATUS_ACCEPT, 1'b0));
      directed.push_back(item_row(ROW_PREDICT, FUNC_DATA, 0, 0, 8'h11, STATUS_SPI, 1'b0));
      directed.push_back(item_row(ROW_PREDICT, FUNC_DATA, 0, 0, 8'h22, STATUS_SPI, 1'b0));
      directed.push_back(item_row(ROW_PREDICT, FUNC_DATA, 0, 0, 8'h33, STATUS_SPI, 1'b0));
      directed.push_back(item_row(ROW_PREDICT, FUNC_READ, 8191, 1, 8'h00, STATUS_SPI, 1'b0));
      // An empty region still takes zero-length requests.
      directed.push_back(csr_row(CSR_REGION_SIZE, 0));
      directed.push_back(item_row(ROW_PREDICT, FUNC_READ, 0, 0, 8'h00, STATUS_SPI, 1'b0));
      directed.push_back(item_row(ROW_TYPED, FUNC_WRITE, 0, 1, 8'h00, STATUS_RANGE, 1'b0));
      directed.push_back(item_row(ROW_TYPED, FUNC_WRITE, 0, 0, 8'h00, STATUS_ACCEPT, 1'b1));
      directed.push_back(csr_row(CSR_REGION_BASE, 0));
      directed.push_back(csr_row(CSR_REGION_SIZE, 8192));

      // Synchronous reset, released at a falling edge.
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         case (directed[i].kind)
            ROW_CSR: begin
               write_csr(directed[i].sel, directed[i].it.byte_count);
            end
            ROW_TYPED: begin
               send_item(directed[i].it, 1'b1,
                         frame(directed[i].st, 8'h00, 1'b0, 1'b0, directed[i].wr, 1'b1));
            end
            default: begin
               send_item(directed[i].it, 1'b0, '0);
            end
         endcase
      end

      // Random phases, each under its own region. Every phase closes any
      // write it opened before the region changes again.
      for (int phase = 0; phase < RandomPhases; phase++) begin
         case (phase)
            0: begin
               base_pick = 14'(8191);
               size_pick = 14'(8192);
            end
            1: begin
               base_pick = 14'($urandom_range(0, 8191));
               size_pick = 14'($urandom_range(0, 300));
            end
            2: begin
               base_pick = 14'($urandom_range(8000, 8191));
               size_pick = 14'($urandom_range(0, 8192));
            end
            default: begin
               base_pick = 14'($urandom_range(0, 8191));
               size_pick = 14'($urandom_range(33, 8192));
            end
         endcase
         write_csr(CSR_REGION_BASE, base_pick);
         write_csr(CSR_REGION_SIZE, size_pick);
         sent = 0;
         while (sent < PhaseItems || bytes_left != 0) begin
            send_item(random_item(), 1'b0, '0);
            sent++;
         end
      end
      req_tvalid = 1'b0;

      // Wait for every owed result, then run on for a drain period to catch extras.
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (n_fail == 0) begin
         $display("spi_eeprom_page_write_framer test passed");
      end else begin
         $display("spi_eeprom_page_write_framer test failed");
      end
      $finish;
   end

endmodule : spi_eeprom_page_write_framer_tb
